FILE: hdl/assert_macros.svh
// assertion macros for the quaternion unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: hdl/qau_pkg.sv
// package with types, constants and helpers of the quaternion unit
`timescale 1ns / 1ps
`default_nettype none
package qau_pkg;
  localparam int DataWidth = 16;
  localparam int FracBits = 12;
  localparam int ProdWidth = 2 * DataWidth;
  localparam int AccWidth = ProdWidth + 3;
  localparam int SqWidth = ProdWidth + 2;
  localparam int NumWidth = DataWidth + FracBits + 1;
  // rounded squared norm reaches 2^(2*DataWidth-FracBits)
  localparam int DenWidth = ProdWidth - FracBits + 1;

  typedef logic signed [DataWidth-1:0] data_t;

  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdSub = 3'd1;
  localparam logic [2:0] CmdMul = 3'd2;
  localparam logic [2:0] CmdConj = 3'd3;
  localparam logic [2:0] CmdInv = 3'd4;
  localparam logic [2:0] CmdNorm = 3'd5;
  localparam logic [2:0] CmdDot = 3'd6;
  localparam logic [2:0] CmdMat = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    data_t a_w;
    data_t a_x;
    data_t a_y;
    data_t a_z;
    data_t b_w;
    data_t b_x;
    data_t b_y;
    data_t b_z;
  } in_item_t;

  typedef struct packed {
    data_t r0;
    data_t r1;
    data_t r2;
    data_t r3;
    logic last;
    logic zero_norm;
    logic saturated;
  } out_item_t;

  localparam logic signed [AccWidth-1:0] OneAcc = AccWidth'(1) <<< FracBits;

  // round to nearest, ties up, with shift sh
  function automatic logic signed [AccWidth-1:0] rnd(input logic signed [AccWidth-1:0] v,
                                                     input int sh);
    logic signed [AccWidth-1:0] t;
    t = v + (AccWidth'(1) <<< (sh - 1));
    return t >>> sh;
  endfunction

  // clip to data range, flag set on clip
  function automatic logic [DataWidth:0] clip(input logic signed [AccWidth-1:0] v);
    logic signed [AccWidth-1:0] hi;
    logic signed [AccWidth-1:0] lo;
    hi = AccWidth'((64'sd1 <<< (DataWidth - 1)) - 1);
    lo = -hi - AccWidth'(1);
    if (v > hi) return {1'b1, hi[DataWidth-1:0]};
    if (v < lo) return {1'b1, lo[DataWidth-1:0]};
    return {1'b0, v[DataWidth-1:0]};
  endfunction
endpackage
`default_nettype wire

FILE: hdl/quaternion_arithmetic_unit_top.sv
// top level of the quaternion arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Quaternion unit in signed Q3.12. An item is taken when start is high and
// busy is low; results come out one per cycle marked by done, and cannot be
// held off. Non-matrix items give one result, to_matrix gives four rows,
// last marks the final one. The arithmetic pipeline takes a new item every
// cycle while busy is low; it is made up of three front stages, the pipelined
// square root (17 root bits, one per stage, plus a rounding stage) and the
// pipelined restoring dividers (30 quotient bits, one per stage, plus an input
// stage), and it ends in the result queue. The other rows of a matrix item
// follow its first row back to back. Items other than to_matrix stream at one
// per cycle while busy is low. Once a matrix item is taken, busy stays high
// until it reaches the result queue, so the next item is taken only after
// that; busy is also high while the queue holds two or more entries. Nothing
// in flight is ever dropped.
module quaternion_arithmetic_unit_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire qau_pkg::in_item_t in_item,
  output logic busy,
  output logic done,
  output qau_pkg::out_item_t result
);
  import qau_pkg::*;
  logic cv;
  in_item_t cop;
  logic [3:0][AccWidth-1:0] r0, r1, r2;
  logic zn, full, acc;
  // credit count of items in the pipe or queue
  logic [7:0] inflight;

  assign acc = start && !busy;

  qau_core u_core (.clk(clk), .rst(rst), .in_vld(acc), .in_item(in_item),
                   .out_vld(cv), .out_op(cop), .row0(r0), .row1(r1), .row2(r2),
                   .zn(zn));

  qau_emit u_emit (.clk(clk), .rst(rst), .in_vld(cv), .op(cop), .row0(r0),
                   .row1(r1), .row2(r2), .zn(zn), .full(full), .out_vld(done),
                   .out_item(result));

  // matrix items are throttled by tracking outstanding matrix work
  logic [7:0] mats;
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
      mats <= '0;
    end else begin
      inflight <= inflight + 8'(acc) - 8'(done && result.last);
      mats <= mats + 8'(acc && in_item.cmd == CmdMat) - 8'(cv && cop.cmd == CmdMat);
    end
  end
  assign busy = full || (mats != '0);

  `ASSERT_NEVER(a_no_under, clk, rst, done && result.last && inflight == '0)
  `ASSERT_IMPLIES(a_zn_last, clk, rst, done && result.zero_norm, result.last)
endmodule
`default_nettype wire

FILE: hdl/qau_isqrt.sv
// pipelined integer square root, one result bit per stage, rounded
`timescale 1ns / 1ps
`default_nettype none
module qau_isqrt (
  input  wire logic clk,
  input  wire logic [qau_pkg::SqWidth-1:0] din,
  output logic [qau_pkg::SqWidth/2:0] root
);
  import qau_pkg::*;
  localparam int Steps = SqWidth / 2;
  logic [SqWidth-1:0] rem [Steps+1];
  logic [Steps-1:0] res [Steps+1];

  always_comb begin
    rem[0] = din;
    res[0] = '0;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_st
    localparam int Sh = 2 * (Steps - 1 - i);
    logic [SqWidth-1:0] trial;
    // (root so far + new bit)^2 minus (root so far)^2
    always_comb begin
      trial = ({(SqWidth - Steps)'(0), res[i]} << (Sh + 2)) | (SqWidth'(1) << Sh);
    end
    always_ff @(posedge clk) begin
      if (rem[i] >= trial) begin
        rem[i+1] <= rem[i] - trial;
        res[i+1] <= {res[i][Steps-2:0], 1'b1};
      end else begin
        rem[i+1] <= rem[i];
        res[i+1] <= {res[i][Steps-2:0], 1'b0};
      end
    end
  end

  // remainder beyond r rounds up
  always_ff @(posedge clk) begin
    if (rem[Steps] > {(SqWidth - Steps)'(0), res[Steps]}) begin
      root <= {1'b0, res[Steps]} + 1'b1;
    end else begin
      root <= {1'b0, res[Steps]};
    end
  end
endmodule
`default_nettype wire

FILE: hdl/qau_div.sv
// pipelined signed divider, restoring, one quotient bit per stage, rounds half away
`timescale 1ns / 1ps
`default_nettype none
module qau_div (
  input  wire logic clk,
  input  wire logic signed [qau_pkg::NumWidth-1:0] num,
  input  wire logic [qau_pkg::DenWidth-1:0] den,
  output logic signed [qau_pkg::AccWidth-1:0] quo
);
  import qau_pkg::*;
  localparam int DW = DenWidth;
  localparam int NW = NumWidth + 1;
  // magnitude plus half the divisor, then plain division
  logic [NW-1:0] mag0;
  logic [NW-1:0] num_s [NW+1];
  logic [NW-1:0] rem_s [NW+1];
  logic [NW-1:0] q_s [NW+1];
  logic [DW-1:0] d_s [NW+1];
  logic neg_s [NW+1];

  always_comb begin
    mag0 = num[NumWidth-1] ? NW'(-{num[NumWidth-1], num}) : NW'({1'b0, num});
  end

  always_ff @(posedge clk) begin
    num_s[0] <= mag0 + NW'(den >> 1);
    rem_s[0] <= '0;
    q_s[0] <= '0;
    d_s[0] <= den;
    neg_s[0] <= num[NumWidth-1];
  end

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [NW:0] tr;
    always_comb tr = {rem_s[i], num_s[i][NW-1]};
    always_ff @(posedge clk) begin
      d_s[i+1] <= d_s[i];
      neg_s[i+1] <= neg_s[i];
      num_s[i+1] <= num_s[i] << 1;
      if (tr >= (NW + 1)'(d_s[i]) && d_s[i] != '0) begin
        rem_s[i+1] <= NW'(tr - (NW + 1)'(d_s[i]));
        q_s[i+1] <= {q_s[i][NW-2:0], 1'b1};
      end else begin
        rem_s[i+1] <= NW'(tr);
        q_s[i+1] <= {q_s[i][NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    quo = neg_s[NW] ? -AccWidth'(q_s[NW]) : AccWidth'(q_s[NW]);
  end
endmodule
`default_nettype wire

FILE: hdl/qau_core.sv
// arithmetic pipeline: products, sums, square root, division and rounding for all commands
`timescale 1ns / 1ps
`default_nettype none
module qau_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_vld,
  input  wire qau_pkg::in_item_t in_item,
  output logic out_vld,
  output qau_pkg::in_item_t out_op,
  output logic [3:0][qau_pkg::AccWidth-1:0] row0,
  output logic [3:0][qau_pkg::AccWidth-1:0] row1,
  output logic [3:0][qau_pkg::AccWidth-1:0] row2,
  output logic zn
);
  import qau_pkg::*;

  // stage 1: products
  in_item_t op1;
  logic v1;
  logic signed [ProdWidth-1:0] pm [4][4];
  logic signed [ProdWidth-1:0] pa [4][4];
  data_t av [4];
  data_t bv [4];
  always_comb begin
    av = '{in_item.a_w, in_item.a_x, in_item.a_y, in_item.a_z};
    bv = '{in_item.b_w, in_item.b_x, in_item.b_y, in_item.b_z};
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_vld;
    op1 <= in_item;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pa[i][j] <= ProdWidth'(av[i]) * ProdWidth'(av[j]);
        pm[i][j] <= ProdWidth'(av[i]) * ProdWidth'(bv[j]);
      end
    end
  end

  // stage 2: exact sums
  function automatic logic signed [AccWidth-1:0] e(input logic signed [ProdWidth-1:0] p);
    return AccWidth'(p);
  endfunction
  in_item_t op2;
  logic v2;
  logic signed [AccWidth-1:0] s2 [12];
  logic [SqWidth-1:0] sq2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    op2 <= op1;
    s2[0] <= e(pm[0][0]) - e(pm[1][1]) - e(pm[2][2]) - e(pm[3][3]);
    s2[1] <= e(pm[0][1]) + e(pm[1][0]) + e(pm[2][3]) - e(pm[3][2]);
    s2[2] <= e(pm[0][2]) - e(pm[1][3]) + e(pm[2][0]) + e(pm[3][1]);
    s2[3] <= e(pm[0][3]) + e(pm[1][2]) - e(pm[2][1]) + e(pm[3][0]);
    s2[4] <= e(pm[0][0]) + e(pm[1][1]) + e(pm[2][2]) + e(pm[3][3]);
    s2[5] <= e(pa[2][2]) + e(pa[3][3]);
    s2[6] <= e(pa[1][2]) - e(pa[0][3]);
    s2[7] <= e(pa[1][3]) + e(pa[0][2]);
    s2[8] <= e(pa[1][2]) + e(pa[0][3]);
    s2[9] <= e(pa[1][1]) + e(pa[3][3]);
    s2[10] <= e(pa[2][3]) - e(pa[0][1]);
    s2[11] <= e(pa[1][3]) - e(pa[0][2]);
    sq2 <= SqWidth'($unsigned(pa[0][0])) + SqWidth'($unsigned(pa[1][1]))
         + SqWidth'($unsigned(pa[2][2])) + SqWidth'($unsigned(pa[3][3]));
  end

  // stage 3: rounding and two extra sums
  in_item_t op3;
  logic v3;
  logic [3:0][AccWidth-1:0] r0_3, r1_3, r2_3;
  logic [3:0][AccWidth-1:0] r0_next, r1_next, r2_next;
  logic [SqWidth-1:0] sq3;
  logic [DenWidth-1:0] n2_3;
  logic signed [AccWidth-1:0] pyz, pxz2, pxy;
  always_comb begin
    pyz = e(pa[2][3]) + e(pa[0][1]);
    pxz2 = e(pa[1][1]) + e(pa[2][2]);
  end
  // keep two more registered sums for row 2 diag and row 2 col 1
  logic signed [AccWidth-1:0] s2b [2];
  always_ff @(posedge clk) begin
    s2b[0] <= pyz;
    s2b[1] <= pxz2;
  end
  always_comb pxy = s2b[0];

  always_comb begin
    r0_next = '0;
    r1_next = '0;
    r2_next = '0;
    unique case (op2.cmd)
      CmdAdd: begin
        r0_next[0] = AccWidth'(op2.a_w) + AccWidth'(op2.b_w);
        r0_next[1] = AccWidth'(op2.a_x) + AccWidth'(op2.b_x);
        r0_next[2] = AccWidth'(op2.a_y) + AccWidth'(op2.b_y);
        r0_next[3] = AccWidth'(op2.a_z) + AccWidth'(op2.b_z);
      end
      CmdSub: begin
        r0_next[0] = AccWidth'(op2.a_w) - AccWidth'(op2.b_w);
        r0_next[1] = AccWidth'(op2.a_x) - AccWidth'(op2.b_x);
        r0_next[2] = AccWidth'(op2.a_y) - AccWidth'(op2.b_y);
        r0_next[3] = AccWidth'(op2.a_z) - AccWidth'(op2.b_z);
      end
      CmdMul: begin
        for (int i = 0; i < 4; i++) r0_next[i] = rnd(s2[i], FracBits);
      end
      CmdConj: begin
        r0_next[0] = AccWidth'(op2.a_w);
        r0_next[1] = -AccWidth'(op2.a_x);
        r0_next[2] = -AccWidth'(op2.a_y);
        r0_next[3] = -AccWidth'(op2.a_z);
      end
      CmdDot: r0_next[0] = rnd(s2[4], FracBits);
      CmdMat: begin
        r0_next[0] = OneAcc - rnd(s2[5], FracBits - 1);
        r0_next[1] = rnd(s2[6], FracBits - 1);
        r0_next[2] = rnd(s2[7], FracBits - 1);
        r1_next[0] = rnd(s2[8], FracBits - 1);
        r1_next[1] = OneAcc - rnd(s2[9], FracBits - 1);
        r1_next[2] = rnd(s2[10], FracBits - 1);
        r2_next[0] = rnd(s2[11], FracBits - 1);
        r2_next[1] = rnd(pxy, FracBits - 1);
        r2_next[2] = OneAcc - rnd(s2b[1], FracBits - 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    op3 <= op2;
    sq3 <= sq2;
    n2_3 <= DenWidth'((sq2 >> FracBits) + SqWidth'(sq2[FracBits-1]));
    r0_3 <= r0_next;
    r1_3 <= r1_next;
    r2_3 <= r2_next;
  end

  // square root path and division path, kept in lockstep with delay lines
  logic [SqWidth/2:0] root;
  qau_isqrt u_sqrt (.clk(clk), .din(sq3), .root(root));

  localparam int SqLat = SqWidth / 2 + 1;
  in_item_t op_d [SqLat+1];
  logic v_d [SqLat+1];
  logic [3:0][AccWidth-1:0] r0_d [SqLat+1];
  logic [3:0][AccWidth-1:0] r1_d [SqLat+1];
  logic [3:0][AccWidth-1:0] r2_d [SqLat+1];
  logic [DenWidth-1:0] n2_d [SqLat+1];
  always_comb begin
    op_d[0] = op3; v_d[0] = v3; r0_d[0] = r0_3; r1_d[0] = r1_3; r2_d[0] = r2_3;
    n2_d[0] = n2_3;
  end
  for (genvar k = 0; k < SqLat; k++) begin : g_d
    always_ff @(posedge clk) begin
      if (rst) v_d[k+1] <= 1'b0;
      else v_d[k+1] <= v_d[k];
      op_d[k+1] <= op_d[k];
      r0_d[k+1] <= r0_d[k];
      r1_d[k+1] <= r1_d[k];
      r2_d[k+1] <= r2_d[k];
      n2_d[k+1] <= n2_d[k];
    end
  end

  in_item_t opq;
  logic [DenWidth-1:0] den;
  logic signed [NumWidth-1:0] num [4];
  always_comb begin
    opq = op_d[SqLat];
    den = (opq.cmd == CmdInv) ? n2_d[SqLat] : DenWidth'(root);
    num[0] = NumWidth'(opq.a_w) <<< FracBits;
    num[1] = (opq.cmd == CmdInv) ? -(NumWidth'(opq.a_x) <<< FracBits)
                                 : NumWidth'(opq.a_x) <<< FracBits;
    num[2] = (opq.cmd == CmdInv) ? -(NumWidth'(opq.a_y) <<< FracBits)
                                 : NumWidth'(opq.a_y) <<< FracBits;
    num[3] = (opq.cmd == CmdInv) ? -(NumWidth'(opq.a_z) <<< FracBits)
                                 : NumWidth'(opq.a_z) <<< FracBits;
  end
  logic signed [AccWidth-1:0] qv [4];
  for (genvar k = 0; k < 4; k++) begin : g_div
    qau_div u_div (.clk(clk), .num(num[k]), .den(den), .quo(qv[k]));
  end

  localparam int DL = NumWidth + 2;
  in_item_t op_e [DL+1];
  logic v_e [DL+1];
  logic [3:0][AccWidth-1:0] r0_e [DL+1];
  logic [3:0][AccWidth-1:0] r1_e [DL+1];
  logic [3:0][AccWidth-1:0] r2_e [DL+1];
  logic z_e [DL+1];
  always_comb begin
    op_e[0] = opq; v_e[0] = v_d[SqLat]; r0_e[0] = r0_d[SqLat];
    r1_e[0] = r1_d[SqLat]; r2_e[0] = r2_d[SqLat];
    z_e[0] = (n2_d[SqLat] == '0);
  end
  for (genvar k = 0; k < DL; k++) begin : g_e
    always_ff @(posedge clk) begin
      if (rst) v_e[k+1] <= 1'b0;
      else v_e[k+1] <= v_e[k];
      op_e[k+1] <= op_e[k];
      r0_e[k+1] <= r0_e[k];
      r1_e[k+1] <= r1_e[k];
      r2_e[k+1] <= r2_e[k];
      z_e[k+1] <= z_e[k];
    end
  end

  logic is_div;
  always_comb begin
    is_div = (op_e[DL].cmd == CmdInv) || (op_e[DL].cmd == CmdNorm);
    out_vld = v_e[DL];
    out_op = op_e[DL];
    row1 = r1_e[DL];
    row2 = r2_e[DL];
    zn = is_div && z_e[DL];
    row0 = r0_e[DL];
    if (is_div) begin
      if (z_e[DL]) row0 = {AccWidth'(0), AccWidth'(0), AccWidth'(0), OneAcc};
      else row0 = {qv[3], qv[2], qv[1], qv[0]};
    end
  end
endmodule
`default_nettype wire

FILE: hdl/qau_emit.sv
// output sequencer: one row per item, four rows for matrix items, with a queue
`timescale 1ns / 1ps
`default_nettype none
module qau_emit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_vld,
  input  wire qau_pkg::in_item_t op,
  input  wire logic [3:0][qau_pkg::AccWidth-1:0] row0,
  input  wire logic [3:0][qau_pkg::AccWidth-1:0] row1,
  input  wire logic [3:0][qau_pkg::AccWidth-1:0] row2,
  input  wire logic zn,
  output logic full,
  output logic out_vld,
  output qau_pkg::out_item_t out_item
);
  import qau_pkg::*;
  localparam int Depth = 4;
  typedef struct packed {
    logic mat;
    logic zn;
    logic [3:0][AccWidth-1:0] r0;
    logic [3:0][AccWidth-1:0] r1;
    logic [3:0][AccWidth-1:0] r2;
  } ent_t;
  ent_t mem [Depth];
  logic [1:0] wp, rp, beat;
  logic [2:0] cnt;
  ent_t cur;
  logic [3:0][AccWidth-1:0] rowv;
  logic [DataWidth:0] c [4];
  logic pop;

  always_comb begin
    cur = mem[rp];
    unique case (beat)
      2'd0: rowv = cur.r0;
      2'd1: rowv = cur.r1;
      2'd2: rowv = cur.r2;
      default: rowv = {OneAcc, AccWidth'(0), AccWidth'(0), AccWidth'(0)};
    endcase
    for (int i = 0; i < 4; i++) c[i] = clip(rowv[i]);
    pop = (cnt != '0) && (!cur.mat || beat == 2'd3);
    full = (cnt >= 3'd2);
  end

  always_ff @(posedge clk) begin
    if (in_vld) mem[wp] <= '{op.cmd == CmdMat, zn, row0, row1, row2};
    out_item <= '{c[0][DataWidth-1:0], c[1][DataWidth-1:0], c[2][DataWidth-1:0],
                  c[3][DataWidth-1:0], pop, cur.zn && !cur.mat,
                  c[0][DataWidth] | c[1][DataWidth] | c[2][DataWidth] | c[3][DataWidth]};
    if (rst) begin
      wp <= '0; rp <= '0; beat <= '0; cnt <= '0; out_vld <= 1'b0;
    end else begin
      out_vld <= (cnt != '0);
      if (in_vld) wp <= wp + 1'b1;
      if (pop) begin
        rp <= rp + 1'b1;
        beat <= '0;
      end else if (cnt != '0) begin
        beat <= beat + 1'b1;
      end
      cnt <= cnt + 3'(in_vld) - 3'(pop);
    end
  end
endmodule
`default_nettype wire
